### sv/lmfc_pkg.sv
// Package for the lamp mode fade controller.
// Holds the mode codes, register indexes, reset values and field widths.
// No dependencies; imported by lamp_mode_fade_controller_unit.
package lmfc_pkg;

    // Field and register widths.
    localparam int SEL_W  = 16;
    localparam int RUN_W  = 24;
    localparam int FADE_W = 16;
    localparam int DUTY_W = 8;
    localparam int MODE_W = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Lamp modes, encoded as shown on the mode output.
    typedef enum logic [MODE_W-1:0] {
        MODE_OFF   = 4'd0,
        MODE_FIRST = 4'd1,
        MODE_LOW   = 4'd2,
        MODE_WAIT1 = 4'd3,
        MODE_MED   = 4'd4,
        MODE_WAIT2 = 4'd5,
        MODE_HIGH  = 4'd6,
        MODE_WAIT3 = 4'd7,
        MODE_FADE  = 4'd8
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SELECT_WINDOW = 3'd0,
        CFG_RUNTIME_LIMIT = 3'd1,
        CFG_FADE_INTERVAL = 3'd2,
        CFG_LEVEL_LOW     = 3'd3,
        CFG_LEVEL_MEDIUM  = 3'd4,
        CFG_LEVEL_HIGH    = 3'd5
    } cfg_idx_t;

    // Register reset values.
    localparam logic [SEL_W-1:0]  SELECT_WINDOW_RST = 16'd500;
    localparam logic [RUN_W-1:0]  RUNTIME_LIMIT_RST = 24'd600000;
    localparam logic [FADE_W-1:0] FADE_INTERVAL_RST = 16'd50;
    localparam logic [DUTY_W-1:0] LEVEL_LOW_RST     = 8'd20;
    localparam logic [DUTY_W-1:0] LEVEL_MEDIUM_RST  = 8'd60;
    localparam logic [DUTY_W-1:0] LEVEL_HIGH_RST    = 8'd120;

    // Breathing ramp limits.
    localparam logic [DUTY_W-1:0] FADE_CEIL = 8'd121;
    localparam logic [DUTY_W-1:0] FADE_TOP  = 8'd120;

endpackage

### sv/lamp_mode_fade_controller_unit.sv
// Single-button LED lamp mode controller with breathing fade.
// Mode machine, saturating timers, configuration registers and result register.
// Depends on lmfc_pkg.
//
// The result word for an input word is valid in the cycle after it is accepted.
// Throughput: one word per cycle; a word is taken whenever the result register is
// empty or is being drained in the same cycle.
// Reset (rst_n low, asynchronous): mode off, duty 0, fade direction up, timers 0,
// configuration registers at their default values, no result pending.
module lamp_mode_fade_controller_unit
    import lmfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  button_pressed,
    input  logic                  tick,
    // Result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DUTY_W-1:0]     duty,
    output logic [MODE_W-1:0]     mode,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic [SEL_W-1:0]  select_window_reg;
    logic [RUN_W-1:0]  runtime_limit_reg;
    logic [FADE_W-1:0] fade_interval_reg;
    logic [DUTY_W-1:0] level_low_reg;
    logic [DUTY_W-1:0] level_medium_reg;
    logic [DUTY_W-1:0] level_high_reg;

    // Lamp state; mode and duty double as the result register.
    mode_t             mode_state_reg, mode_state_next;
    logic [DUTY_W-1:0] duty_level_reg, duty_level_next;
    logic              fade_rising_reg, fade_rising_next;
    logic [SEL_W-1:0]  select_count_reg, select_count_next;
    logic [RUN_W-1:0]  run_count_reg, run_count_next;
    logic [FADE_W-1:0] fade_count_reg, fade_count_next;
    logic              out_valid_reg;

    // Timer values after this word's tick.
    logic [SEL_W-1:0]  sel_t;
    logic [RUN_W-1:0]  run_t;
    logic [FADE_W-1:0] fade_t;
    logic              accept;
    logic              quick_press;
    logic              sel_timeout;
    logic              run_expired;

    // Handshake: a word is taken when the result slot is free or being emptied.
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign duty      = duty_level_reg;
    assign mode      = mode_state_reg;

    // Saturating timer advance.
    assign sel_t  = (tick && (select_count_reg != '1)) ? select_count_reg + 1'b1
                                                       : select_count_reg;
    assign run_t  = (tick && (run_count_reg != '1)) ? run_count_reg + 1'b1
                                                    : run_count_reg;
    assign fade_t = (tick && (fade_count_reg != '1)) ? fade_count_reg + 1'b1
                                                     : fade_count_reg;

    assign quick_press = button_pressed && (sel_t < select_window_reg);
    assign sel_timeout = sel_t > select_window_reg;
    assign run_expired = run_t > runtime_limit_reg;

    // Next mode.
    always_comb
    begin
        mode_state_next = mode_state_reg;
        unique case (mode_state_reg)
            MODE_OFF:
            begin
                if (button_pressed)
                    mode_state_next = MODE_FIRST;
            end
            MODE_FIRST:
            begin
                if (quick_press)
                    mode_state_next = MODE_FADE;
                else if (sel_timeout)
                    mode_state_next = MODE_LOW;
            end
            MODE_LOW, MODE_MED, MODE_HIGH:
            begin
                if (run_expired)
                    mode_state_next = MODE_OFF;
                else if (button_pressed)
                    mode_state_next = mode_t'(mode_state_reg + 1'b1);
            end
            MODE_WAIT1, MODE_WAIT2:
            begin
                if (quick_press)
                    mode_state_next = MODE_OFF;
                else if (sel_timeout)
                    mode_state_next = mode_t'(mode_state_reg + 1'b1);
            end
            MODE_WAIT3:
            begin
                if (quick_press)
                    mode_state_next = MODE_OFF;
                else if (sel_timeout)
                    mode_state_next = MODE_LOW;
            end
            MODE_FADE:
            begin
                if (button_pressed || run_expired)
                    mode_state_next = MODE_OFF;
            end
            default:
            begin
                mode_state_next = mode_state_reg;
            end
        endcase
    end

    // Duty, fade direction and timer updates.
    always_comb
    begin
        logic [DUTY_W-1:0] d;
        logic              r;
        d = duty_level_reg;
        r = fade_rising_reg;
        duty_level_next   = duty_level_reg;
        fade_rising_next  = fade_rising_reg;
        select_count_next = sel_t;
        run_count_next    = run_t;
        fade_count_next   = fade_t;
        unique case (mode_state_reg)
            MODE_OFF:
            begin
                duty_level_next = '0;
                if (button_pressed)
                    select_count_next = '0;
            end
            MODE_FIRST:
            begin
                if (quick_press)
                begin
                    duty_level_next = '0;
                    fade_count_next = '0;
                    run_count_next  = '0;
                end
                else if (sel_timeout)
                    run_count_next = '0;
            end
            MODE_LOW, MODE_MED, MODE_HIGH:
            begin
                if (mode_state_reg == MODE_LOW)
                    duty_level_next = level_low_reg;
                else if (mode_state_reg == MODE_MED)
                    duty_level_next = level_medium_reg;
                else
                    duty_level_next = level_high_reg;
                if (button_pressed)
                    select_count_next = '0;
            end
            MODE_WAIT1, MODE_WAIT2, MODE_WAIT3:
            begin
                if (!quick_press && sel_timeout)
                    run_count_next = '0;
            end
            MODE_FADE:
            begin
                // One ramp step: up to the top then turn, down to one then turn.
                if (fade_t > fade_interval_reg)
                begin
                    if (r && (d < FADE_CEIL))
                    begin
                        d = d + 1'b1;
                        if (d == FADE_TOP)
                            r = 1'b0;
                    end
                    if (!r && (d != '0))
                    begin
                        d = d - 1'b1;
                        if (d == DUTY_W'(1))
                            r = 1'b1;
                    end
                    fade_count_next = '0;
                end
                duty_level_next  = d;
                fade_rising_next = r;
            end
            default:
            begin
                duty_level_next = duty_level_reg;
            end
        endcase
    end

    // State and result registers, updated on each accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_state_reg   <= MODE_OFF;
            duty_level_reg   <= '0;
            fade_rising_reg  <= 1'b1;
            select_count_reg <= '0;
            run_count_reg    <= '0;
            fade_count_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_state_reg   <= mode_state_next;
                duty_level_reg   <= duty_level_next;
                fade_rising_reg  <= fade_rising_next;
                select_count_reg <= select_count_next;
                run_count_reg    <= run_count_next;
                fade_count_reg   <= fade_count_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_window_reg <= SELECT_WINDOW_RST;
            runtime_limit_reg <= RUNTIME_LIMIT_RST;
            fade_interval_reg <= FADE_INTERVAL_RST;
            level_low_reg     <= LEVEL_LOW_RST;
            level_medium_reg  <= LEVEL_MEDIUM_RST;
            level_high_reg    <= LEVEL_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SELECT_WINDOW: select_window_reg <= cfg_data[SEL_W-1:0];
                CFG_RUNTIME_LIMIT: runtime_limit_reg <= cfg_data[RUN_W-1:0];
                CFG_FADE_INTERVAL: fade_interval_reg <= cfg_data[FADE_W-1:0];
                CFG_LEVEL_LOW:     level_low_reg     <= cfg_data[DUTY_W-1:0];
                CFG_LEVEL_MEDIUM:  level_medium_reg  <= cfg_data[DUTY_W-1:0];
                CFG_LEVEL_HIGH:    level_high_reg    <= cfg_data[DUTY_W-1:0];
                default:           ;
            endcase
        end
    end

    // Assertions

    // An empty result register never blocks the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    // Every accepted word produces a result word in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted word produced no result");

    // The breathing ramp never exceeds its top value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_state_reg == MODE_FADE) |-> (duty_level_reg <= FADE_TOP))
        else $error("fade duty above ramp top");

    // Moving from the first-press mode to low restarts the runtime timer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode_state_reg == MODE_FIRST) && (mode_state_next == MODE_LOW))
        |=> (run_count_reg == '0))
        else $error("runtime timer not cleared on entry to low");

    // Without an accepted word the lamp state holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(mode_state_reg) && $stable(duty_level_reg)))
        else $error("lamp state changed without an accepted word");

endmodule
